/* sv/fsrp_pkg.sv */
// Shared types, constants and helpers for the five-stage pipeline block.
package fsrp_pkg;

   localparam int MEM_WORDS_DEFAULT = 256;

   typedef enum logic [2:0] {
      OP_LOAD_INSTR = 3'd0,
      OP_LOAD_DATA  = 3'd1,
      OP_STEP       = 3'd2,
      OP_READ_REG   = 3'd3,
      OP_READ_DATA  = 3'd4
   } op_type;

   localparam logic [5:0]  OPC_RTYPE  = 6'd0;
   localparam logic [5:0]  OPC_LOAD   = 6'd35;
   localparam logic [5:0]  OPC_STORE  = 6'd43;
   localparam logic [5:0]  OPC_BRANCH = 6'd4;
   localparam logic [5:0]  FUNCT_SUB  = 6'd35;
   localparam logic [31:0] HALT_WORD  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  word_index;
      logic [4:0]  reg_index;
      logic [31:0] load_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        halted;
      logic [9:0]  fetch_address;
      logic        stalled;
      logic        reg_write_valid;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_value;
      logic        mem_write_valid;
      logic [7:0]  mem_write_index;
      logic [31:0] mem_write_value;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] instr;
   } dec_type;

   typedef struct packed {
      logic        valid;
      logic        itype;
      logic        rd;
      logic        wr;
      logic        add;
      logic        wen;
      logic [31:0] rd1;
      logic [31:0] rd2;
      logic [15:0] imm;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  dest;
   } exe_type;

   typedef struct packed {
      logic        valid;
      logic        rd;
      logic        wr;
      logic        wen;
      logic [31:0] alu;
      logic [31:0] sdata;
      logic [4:0]  dest;
   } mem_type;

   typedef struct packed {
      logic        valid;
      logic        wen;
      logic [31:0] data;
      logic [4:0]  dest;
   } wb_type;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

/* sv/fsrp_if.sv */
// Valid/ready channel carrying one payload struct.
interface fsrp_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/fsrp_core.sv */
// Pipeline state, memories and a one-step advance of the pipeline for each step transfer.
module fsrp_core #(
   parameter int MEM_WORDS = fsrp_pkg::MEM_WORDS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  fsrp_pkg::req_type req,
   output fsrp_pkg::rsp_type rsp,
   output logic [31:0]       read_data
);
   localparam int AW = $clog2(MEM_WORDS);

   logic [31:0] imem [MEM_WORDS];
   logic [31:0] dmem [MEM_WORDS];
   logic [31:0] rf_ff [32];
   logic [31:0] rf_in [32];

   logic [9:0]        pc_ff, pc_in;
   logic              done_ff, done_in;
   fsrp_pkg::dec_type dec_ff, dec_in;
   fsrp_pkg::exe_type exe_ff, exe_in;
   fsrp_pkg::mem_type mem_ff, mem_in;
   fsrp_pkg::wb_type  wb_ff, wb_in;

   logic [AW-1:0] req_w, mem_w, pc_w, pc_nw, mem_nw;
   logic          is_step;
   logic [31:0]   dmem_rd_ff, imem_rd_ff, read_ff;

   assign req_w   = AW'(req.word_index);
   assign mem_w   = AW'(mem_ff.alu[31:2]);
   assign pc_w    = AW'(pc_ff[9:2]);
   assign is_step = fire && (req.operation == fsrp_pkg::OP_STEP);
   // addresses that the fetch and memory stages will present after this edge
   assign pc_nw   = reset ? '0 : (is_step ? AW'(pc_in[9:2]) : pc_w);
   assign mem_nw  = is_step ? AW'(mem_in.alu[31:2]) : mem_w;
   assign read_data = read_ff;

   function automatic logic [31:0] fwd(input logic [4:0] r, input logic [31:0] lat,
                                       input fsrp_pkg::mem_type m,
                                       input fsrp_pkg::wb_type w);
      logic [31:0] res;
      res = lat;
      if (r != 5'd0) begin
         if (m.valid && m.wen && !m.rd && m.dest == r) res = m.alu;
         else if (w.valid && w.wen && w.dest == r) res = w.data;
      end
      return res;
   endfunction

   logic [31:0] a, b, op2;
   logic [5:0]  opc;
   logic [4:0]  rs, rt;
   logic        itype, isbr, uses_rt, stall, taken, hz_s, hz_t;
   logic        wb_we, st_we;

   always_comb begin
      // writeback writes before decode reads
      rf_in = rf_ff;
      wb_we = wb_ff.valid && wb_ff.wen && wb_ff.dest != 5'd0;
      if (wb_we) rf_in[wb_ff.dest] = wb_ff.data;

      st_we = mem_ff.valid && mem_ff.wr;
      wb_in = '0;
      if (mem_ff.valid) begin
         wb_in.valid = 1'b1;
         wb_in.wen   = mem_ff.wen;
         wb_in.dest  = mem_ff.dest;
         wb_in.data  = mem_ff.rd ? (st_we ? mem_ff.sdata : dmem_rd_ff) : mem_ff.alu;
      end

      a   = fwd(exe_ff.rs, exe_ff.rd1, mem_ff, wb_ff);
      b   = fwd(exe_ff.rt, exe_ff.rd2, mem_ff, wb_ff);
      op2 = exe_ff.itype ? fsrp_pkg::sext16(exe_ff.imm) : b;
      mem_in = '0;
      if (exe_ff.valid) begin
         mem_in.valid = 1'b1;
         mem_in.alu   = exe_ff.add ? a + op2 : a - op2;
         mem_in.sdata = b;
         mem_in.dest  = exe_ff.dest;
         mem_in.rd    = exe_ff.rd;
         mem_in.wr    = exe_ff.wr;
         mem_in.wen   = exe_ff.wen;
      end

      opc     = dec_ff.instr[31:26];
      rs      = dec_ff.instr[25:21];
      rt      = dec_ff.instr[20:16];
      itype   = opc != fsrp_pkg::OPC_RTYPE;
      isbr    = opc == fsrp_pkg::OPC_BRANCH;
      uses_rt = !itype || opc == fsrp_pkg::OPC_STORE || isbr;
      hz_s = rs != 5'd0 && (
             (exe_ff.valid && exe_ff.rd && exe_ff.wen && exe_ff.dest == rs) ||
             (isbr && ((exe_ff.valid && exe_ff.wen && exe_ff.dest == rs) ||
                       (mem_ff.valid && mem_ff.wen && mem_ff.dest == rs))));
      hz_t = uses_rt && rt != 5'd0 && (
             (exe_ff.valid && exe_ff.rd && exe_ff.wen && exe_ff.dest == rt) ||
             (isbr && ((exe_ff.valid && exe_ff.wen && exe_ff.dest == rt) ||
                       (mem_ff.valid && mem_ff.wen && mem_ff.dest == rt))));
      stall = dec_ff.valid && (hz_s || hz_t);

      exe_in = '0;
      taken  = 1'b0;
      if (dec_ff.valid && !stall) begin
         exe_in.valid = 1'b1;
         exe_in.itype = itype;
         exe_in.rd    = opc == fsrp_pkg::OPC_LOAD;
         exe_in.wr    = opc == fsrp_pkg::OPC_STORE;
         exe_in.add   = !(!itype && dec_ff.instr[5:0] == fsrp_pkg::FUNCT_SUB);
         exe_in.wen   = opc == fsrp_pkg::OPC_LOAD || opc == fsrp_pkg::OPC_RTYPE;
         exe_in.rs    = rs;
         exe_in.rt    = rt;
         exe_in.dest  = itype ? rt : dec_ff.instr[15:11];
         exe_in.imm   = dec_ff.instr[15:0];
         exe_in.rd1   = rf_in[rs];
         exe_in.rd2   = rf_in[rt];
         taken = isbr && (exe_in.rd1 != exe_in.rd2);
      end

      dec_in  = '0;
      pc_in   = pc_ff;
      done_in = done_ff;
      if (stall) begin
         dec_in = dec_ff;
      end else if (taken) begin
         pc_in = pc_ff + {dec_ff.instr[7:0], 2'b00};
      end else if (!done_ff) begin
         if (imem_rd_ff == fsrp_pkg::HALT_WORD) begin
            done_in = 1'b1;
         end else begin
            dec_in.valid = 1'b1;
            dec_in.instr = imem_rd_ff;
            pc_in = pc_ff + 10'd4;
         end
      end
   end

   // read registers always hold the word at the address in use next cycle,
   // with a same-edge write passed straight through
   always_ff @(posedge clock) begin
      if (fire && req.operation == fsrp_pkg::OP_LOAD_INSTR) imem[req_w] <= req.load_value;
      if (fire && req.operation == fsrp_pkg::OP_LOAD_DATA) dmem[req_w] <= req.load_value;
      else if (is_step && st_we) dmem[mem_w] <= mem_ff.sdata;

      if (fire && req.operation == fsrp_pkg::OP_LOAD_INSTR && req_w == pc_nw)
         imem_rd_ff <= req.load_value;
      else
         imem_rd_ff <= imem[pc_nw];

      if (fire && req.operation == fsrp_pkg::OP_LOAD_DATA && req_w == mem_nw)
         dmem_rd_ff <= req.load_value;
      else if (is_step && st_we && mem_w == mem_nw)
         dmem_rd_ff <= mem_ff.sdata;
      else
         dmem_rd_ff <= dmem[mem_nw];

      if (fire) begin
         if (req.operation == fsrp_pkg::OP_READ_DATA) read_ff <= dmem[req_w];
         else if (req.operation == fsrp_pkg::OP_READ_REG) read_ff <= rf_ff[req.reg_index];
         else read_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) rf_ff[i] <= '0;
         pc_ff   <= '0;
         done_ff <= 1'b0;
         dec_ff  <= '0;
         exe_ff  <= '0;
         mem_ff  <= '0;
         wb_ff   <= '0;
      end else if (is_step) begin
         rf_ff   <= rf_in;
         pc_ff   <= pc_in;
         done_ff <= done_in;
         dec_ff  <= dec_in;
         exe_ff  <= exe_in;
         mem_ff  <= mem_in;
         wb_ff   <= wb_in;
      end
   end

   // result fields; state fields reflect values after this transfer.
   // read value is delivered separately from the registered read port.
   always_comb begin
      rsp = '0;
      if (req.operation == fsrp_pkg::OP_STEP) begin
         rsp.stalled         = stall;
         rsp.reg_write_valid = wb_we;
         rsp.reg_write_index = wb_we ? wb_ff.dest : 5'd0;
         rsp.reg_write_value = wb_we ? wb_ff.data : 32'd0;
         rsp.mem_write_valid = st_we;
         rsp.mem_write_index = st_we ? 8'(mem_w) : 8'd0;
         rsp.mem_write_value = st_we ? mem_ff.sdata : 32'd0;
         rsp.fetch_address   = pc_in;
         rsp.halted = done_in && !dec_in.valid && !exe_in.valid && !mem_in.valid
                      && !wb_in.valid;
      end else begin
         rsp.fetch_address = pc_ff;
         rsp.halted = done_ff && !dec_ff.valid && !exe_ff.valid && !mem_ff.valid
                      && !wb_ff.valid;
      end
   end
endmodule

/* sv/five_stage_risc_pipeline.sv */
// A request's result is registered in the response register, or in the skid slot while a response waits.
// Throughput: one request per cycle while the skid slot is empty; each step request advances the pipeline one step.
// A response register with skid slot lets one more request be accepted while a response waits.
// Reset clears the register file, fetch address, halt flag and all stage latches;
// instruction and data memories are not cleared.
module five_stage_risc_pipeline #(
   parameter int MEM_WORDS = fsrp_pkg::MEM_WORDS_DEFAULT
) (
   input logic clock,
   input logic reset,
   fsrp_if.sink   req,
   fsrp_if.source rsp
);
   fsrp_pkg::rsp_type res, out_ff, out_in, skid_ff, rsp_pay;
   logic out_v_ff, skid_v_ff, fire;
   logic [31:0] read_data, out_rd_ff;
   logic        out_fresh_ff;

   assign req.ready = !skid_v_ff;
   assign fire      = req.valid && req.ready;
   assign rsp.valid   = out_v_ff;
   assign rsp.payload = rsp_pay;
   assign out_in = skid_v_ff ? skid_ff : res;

   // the core's read register holds the newest transfer's read value; the
   // output slot keeps a copy once a later transfer lands in the skid slot
   always_comb begin
      rsp_pay = out_ff;
      rsp_pay.read_value = out_fresh_ff ? read_data : out_rd_ff;
   end

   fsrp_core #(.MEM_WORDS(MEM_WORDS)) u_core (
      .clock(clock), .reset(reset), .fire(fire), .req(req.payload), .rsp(res),
      .read_data(read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (!out_v_ff || rsp.ready) begin
            out_v_ff  <= skid_v_ff || fire;
            skid_v_ff <= 1'b0;
         end else if (fire) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp.ready) begin
         out_ff       <= out_in;
         out_fresh_ff <= 1'b1;
      end else if (fire) begin
         skid_ff      <= res;
         out_rd_ff    <= read_data;
         out_fresh_ff <= 1'b0;
      end
   end
endmodule
